// File: rtl/tlg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal Life grid engine package
// Command codes, field widths, register indexes and the types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_BITS_W  = 3;
    localparam int CMD_W       = 3;
    localparam int CFG_W       = 7;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_RUN = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDIT_WR,
        ST_ADV_ZERO,
        ST_ADV_LOAD,
        ST_ADV_ROW,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic take;
        logic rd_item;
        logic edit_wr;
        logic clear_all;
        logic adv_rd_last;
        logic adv_rd_zero;
        logic adv_load;
        logic adv_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             refused;
        logic             on_grid;
        logic             running;
        logic             adv_last;
        logic             out_free;
    } t_dp_status;

endpackage

// File: rtl/tlg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal Life grid controller
// Sequences one command at a time: edit, clear, generation sweep, cell read
// and hand-over of the result beat to the output register.
// ----------------------------------------------------------------------------
module tlg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tlg_pkg::t_dp_status i_sts,
    output tlg_pkg::t_dp_cmd    o_cmd
);

    tlg_pkg::t_state r_state;
    tlg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlg_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tlg_pkg::ST_DECODE;
                end
            end
            tlg_pkg::ST_DECODE: begin
                unique case (i_sts.cmd) inside
                    tlg_pkg::CMD_WRITE, tlg_pkg::CMD_TOGGLE: begin
                        if (!i_sts.refused && i_sts.on_grid) begin
                            n_state = tlg_pkg::ST_EDIT_WR;
                        end else begin
                            n_state = tlg_pkg::ST_READ;
                        end
                    end
                    tlg_pkg::CMD_ADVANCE: begin
                        if (!i_sts.refused) begin
                            n_state = tlg_pkg::ST_ADV_ZERO;
                        end else begin
                            n_state = tlg_pkg::ST_READ;
                        end
                    end
                    default: begin
                        n_state = tlg_pkg::ST_READ;
                    end
                endcase
            end
            tlg_pkg::ST_EDIT_WR:  n_state = tlg_pkg::ST_READ;
            tlg_pkg::ST_ADV_ZERO: n_state = tlg_pkg::ST_ADV_LOAD;
            tlg_pkg::ST_ADV_LOAD: n_state = tlg_pkg::ST_ADV_ROW;
            tlg_pkg::ST_ADV_ROW: begin
                if (i_sts.adv_last) begin
                    n_state = tlg_pkg::ST_READ;
                end
            end
            tlg_pkg::ST_READ: n_state = tlg_pkg::ST_RESP;
            tlg_pkg::ST_RESP: begin
                if (i_sts.out_free) begin
                    n_state = tlg_pkg::ST_IDLE;
                end
            end
            default: n_state = tlg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tlg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            tlg_pkg::ST_DECODE: begin
                unique case (i_sts.cmd) inside
                    tlg_pkg::CMD_WRITE, tlg_pkg::CMD_TOGGLE: begin
                        o_cmd.rd_item = !i_sts.refused && i_sts.on_grid;
                    end
                    tlg_pkg::CMD_CLEAR: begin
                        o_cmd.clear_all = !i_sts.refused;
                    end
                    tlg_pkg::CMD_ADVANCE: begin
                        o_cmd.adv_rd_last = !i_sts.refused;
                    end
                    default: begin
                        o_cmd = '0;
                    end
                endcase
            end
            tlg_pkg::ST_EDIT_WR:  o_cmd.edit_wr = 1'b1;
            tlg_pkg::ST_ADV_ZERO: o_cmd.adv_rd_zero = 1'b1;
            tlg_pkg::ST_ADV_LOAD: o_cmd.adv_load = 1'b1;
            tlg_pkg::ST_ADV_ROW:  o_cmd.adv_step = 1'b1;
            tlg_pkg::ST_READ:     o_cmd.rd_item = 1'b1;
            tlg_pkg::ST_RESP:     o_cmd.out_load = i_sts.out_free;
            default:              o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/tlg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal Life grid datapath
// Row-wide cell store with per-row valid bits, size registers, the three-row
// window and generation rule, and the output register.
// ----------------------------------------------------------------------------
module tlg_datapath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [tlg_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [tlg_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                i_out_ready,
    input  tlg_pkg::t_dp_cmd                    i_cmd,
    output tlg_pkg::t_dp_status                 o_sts,
    output logic                                o_out_valid,
    output logic [tlg_pkg::OUT_TDATA_W-1:0]     o_out_data
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLUMNS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);

    logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]    r_row_vld;
    logic [MAX_COLUMNS-1:0] r_rd_raw;
    logic                   r_rd_vld;

    logic [tlg_pkg::CFG_W-1:0] r_rows_cfg;
    logic [tlg_pkg::CFG_W-1:0] r_cols_cfg;

    logic [tlg_pkg::CMD_W-1:0] r_cmd;
    logic [AW-1:0]             r_row_addr;
    logic [CIW-1:0]            r_col_idx;
    logic                      r_value;
    logic                      r_inside;
    logic                      r_refused;
    logic                      r_run;

    logic [MAX_COLUMNS-1:0] r_prev;
    logic [MAX_COLUMNS-1:0] r_cur;
    logic [MAX_COLUMNS-1:0] r_first;
    logic [AW-1:0]          r_adv_row;

    logic                                r_out_valid;
    logic [tlg_pkg::OUT_BITS_W-1:0]      r_out_bits;

    logic [RCW-1:0]                eff_rows;
    logic [CCW-1:0]                eff_cols;
    logic [AW-1:0]                 last_row;
    logic [CIW-1:0]                last_col;
    logic [tlg_pkg::CMD_W-1:0]     in_cmd;
    logic [5:0]                    in_row;
    logic [5:0]                    in_col;
    logic                          in_val;
    logic                          in_inside;
    logic                          in_refused;
    logic [MAX_COLUMNS-1:0]        rd_row;
    logic [MAX_COLUMNS-1:0]        next_row;
    logic [MAX_COLUMNS-1:0]        gen_row;
    logic [MAX_COLUMNS-1:0]        edit_row;
    logic [MAX_COLUMNS-1:0]        col_mask;
    logic                          adv_last;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [MAX_COLUMNS-1:0]        wr_data;

    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = RCW'(1);
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = CCW'(1);
        end else if (int'(r_cols_cfg) > MAX_COLUMNS) begin
            eff_cols = CCW'(MAX_COLUMNS);
        end else begin
            eff_cols = CCW'(r_cols_cfg);
        end
    end

    assign last_row = AW'(eff_rows - RCW'(1));
    assign last_col = CIW'(eff_cols - CCW'(1));

    assign in_cmd = i_in_data[2:0];
    assign in_row = i_in_data[8:3];
    assign in_col = i_in_data[14:9];
    assign in_val = i_in_data[15];

    assign in_inside = (int'(in_row) < int'(eff_rows)) && (int'(in_col) < int'(eff_cols));

    always_comb begin
        case (in_cmd) inside
            tlg_pkg::CMD_WRITE, tlg_pkg::CMD_TOGGLE, tlg_pkg::CMD_CLEAR: in_refused = r_run;
            tlg_pkg::CMD_ADVANCE: in_refused = !r_run;
            default:              in_refused = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= tlg_pkg::CFG_SIZE_RESET;
            r_cols_cfg <= tlg_pkg::CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlg_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data;
                tlg_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data;
                default:           r_rows_cfg <= r_rows_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_cmd.take && in_cmd == tlg_pkg::CMD_SET_RUN) begin
            r_run <= in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cmd      <= in_cmd;
            r_row_addr <= AW'(in_row);
            r_col_idx  <= CIW'(in_col);
            r_value    <= in_val;
            r_inside   <= in_inside;
            r_refused  <= in_refused;
        end
    end

    assign rd_row   = r_rd_vld ? r_rd_raw : '0;
    assign adv_last = (r_adv_row == last_row);
    assign next_row = adv_last ? r_first : rd_row;

    always_comb begin
        logic [MAX_COLUMNS-1:0] p_l;
        logic [MAX_COLUMNS-1:0] c_l;
        logic [MAX_COLUMNS-1:0] x_l;
        logic [MAX_COLUMNS-1:0] p_r;
        logic [MAX_COLUMNS-1:0] c_r;
        logic [MAX_COLUMNS-1:0] x_r;
        logic                   pr;
        logic                   cr;
        logic                   xr;
        logic [3:0]             n;
        p_l = {r_prev[MAX_COLUMNS-2:0], r_prev[last_col]};
        c_l = {r_cur[MAX_COLUMNS-2:0], r_cur[last_col]};
        x_l = {next_row[MAX_COLUMNS-2:0], next_row[last_col]};
        p_r = {1'b0, r_prev[MAX_COLUMNS-1:1]};
        c_r = {1'b0, r_cur[MAX_COLUMNS-1:1]};
        x_r = {1'b0, next_row[MAX_COLUMNS-1:1]};
        for (int c = 0; c < MAX_COLUMNS; c++) begin
            if (CIW'(c) == last_col) begin
                pr = r_prev[0];
                cr = r_cur[0];
                xr = next_row[0];
            end else begin
                pr = p_r[c];
                cr = c_r[c];
                xr = x_r[c];
            end
            n = 4'(p_l[c]) + 4'(r_prev[c]) + 4'(pr) + 4'(c_l[c]) + 4'(cr)
              + 4'(x_l[c]) + 4'(next_row[c]) + 4'(xr);
            if (CIW'(c) <= last_col) begin
                gen_row[c] = (n == 4'd3) || (r_cur[c] && n == 4'd2);
            end else begin
                gen_row[c] = r_cur[c];
            end
        end
    end

    assign col_mask = {{(MAX_COLUMNS-1){1'b0}}, 1'b1} << r_col_idx;

    always_comb begin
        if (r_cmd == tlg_pkg::CMD_WRITE) begin
            edit_row = r_value ? (rd_row | col_mask) : (rd_row & ~col_mask);
        end else begin
            edit_row = rd_row ^ col_mask;
        end
    end

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_row_addr;
        if (i_cmd.adv_rd_last) begin
            rd_addr = last_row;
        end else if (i_cmd.adv_rd_zero) begin
            rd_addr = '0;
        end else if (i_cmd.adv_load) begin
            rd_addr = AW'(1);
        end else if (i_cmd.adv_step) begin
            rd_addr = AW'(r_adv_row + AW'(2));
        end else if (!i_cmd.rd_item) begin
            rd_en = 1'b0;
        end
    end

    assign wr_en   = i_cmd.edit_wr || i_cmd.adv_step;
    assign wr_addr = i_cmd.adv_step ? r_adv_row : r_row_addr;
    assign wr_data = i_cmd.adv_step ? gen_row : edit_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_raw <= mem[rd_addr];
            r_rd_vld <= r_row_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_cmd.clear_all) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv_rd_zero) begin
            r_prev <= rd_row;
        end else if (i_cmd.adv_load) begin
            r_cur   <= rd_row;
            r_first <= rd_row;
        end else if (i_cmd.adv_step) begin
            r_prev <= r_cur;
            r_cur  <= next_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv_row <= '0;
        end else if (i_cmd.adv_load) begin
            r_adv_row <= '0;
        end else if (i_cmd.adv_step) begin
            r_adv_row <= r_adv_row + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_bits <= {r_refused, r_run, r_inside & rd_row[r_col_idx]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(tlg_pkg::OUT_TDATA_W-tlg_pkg::OUT_BITS_W){1'b0}}, r_out_bits};

    assign o_sts.cmd      = r_cmd;
    assign o_sts.refused  = r_refused;
    assign o_sts.on_grid  = r_inside;
    assign o_sts.running  = r_run;
    assign o_sts.adv_last = adv_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// File: rtl/toroidal_life_grid_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal Life grid engine
// Conway Life on a torus of configurable size, driven by a command stream;
// every command beat returns one result beat.
//
// Channel     Direction  Beat contents
// s_axis      in         command, row, column, value
// m_axis      out        cell_state, running, refused
// cfg         in         size register writes, no read-back
//
// One command is in flight at a time. An advance sweeps the rows in use,
// the cell store giving one row per cycle to the three-row window.
// Reset clears the per-row valid bits, so the grid is dead at once.
// A result beat waiting on m_axis does not hold off the next command beat.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [tlg_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command [2:0], row [8:3], column [14:9], value [15]
    input  logic [tlg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cell_state [0], running [1], refused [2], zeros above
    output logic [tlg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    tlg_pkg::t_dp_cmd    dp_cmd;
    tlg_pkg::t_dp_status dp_sts;

    tlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    tlg_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command beat taken while another is in flight");

    a_step_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.adv_step |-> dp_sts.running)
        else $error("generation step while stopped");

    a_edit_needs_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.edit_wr || dp_cmd.clear_all |-> !dp_sts.running)
        else $error("grid edited while running");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |=> m_axis_tvalid)
        else $error("result beat not presented after load");
`endif

endmodule

// File: tb/sv/toroidal_life_grid_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Toroidal Life grid engine testbench
// Sends command beats through the input stream and checks every result beat
// against a cycle-free model of the grid, its run flag and its size registers.
// A short directed sequence is followed by randomised edit, run and advance
// sessions on grids of many sizes, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module toroidal_life_grid_engine_tb;

    localparam logic [tlg_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [tlg_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int GRID_MAX      = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic refused;
        logic running;
        logic cell_state;
    } life_result_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_idx = 1'b0;
    logic [tlg_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tlg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tlg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    toroidal_life_grid_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [GRID_MAX-1:0]       life_grid [GRID_MAX];
    logic                      life_running;
    logic [tlg_pkg::CFG_W-1:0] rows_reg;
    logic [tlg_pkg::CFG_W-1:0] cols_reg;

    life_result_t pending_results [$];
    int  cycle_count = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  generations_run = 0;
    int  sizes_tried = 0;
    int  burst_left = 0;
    bit  steady_sender = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int size_used(logic [tlg_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return int'(v);
    endfunction

    function automatic void apply_life_rule();
        int nr;
        int nc;
        int live;
        logic [GRID_MAX-1:0] next_grid [GRID_MAX];
        nr = size_used(rows_reg);
        nc = size_used(cols_reg);
        next_grid = life_grid;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            live += life_grid[(r + nr + dr) % nr][(c + nc + dc) % nc];
                        end
                    end
                end
                next_grid[r][c] = life_grid[r][c] ? (live == 2 || live == 3) : (live == 3);
            end
        end
        life_grid = next_grid;
        generations_run++;
    endfunction

    function automatic life_result_t predict_command(logic [tlg_pkg::CMD_W-1:0] cmd,
                                                     logic [5:0] r, logic [5:0] c, logic v);
        life_result_t res;
        logic on_grid;
        on_grid = (r < size_used(rows_reg)) && (c < size_used(cols_reg));
        res.refused = 1'b0;
        case (cmd)
            tlg_pkg::CMD_WRITE, tlg_pkg::CMD_TOGGLE: begin
                if (life_running) begin
                    res.refused = 1'b1;
                end else if (on_grid) begin
                    life_grid[r][c] = (cmd == tlg_pkg::CMD_WRITE) ? v : ~life_grid[r][c];
                end
            end
            tlg_pkg::CMD_CLEAR: begin
                if (life_running) begin
                    res.refused = 1'b1;
                end else begin
                    foreach (life_grid[i]) life_grid[i] = '0;
                end
            end
            tlg_pkg::CMD_ADVANCE: begin
                if (life_running) begin
                    apply_life_rule();
                end else begin
                    res.refused = 1'b1;
                end
            end
            tlg_pkg::CMD_SET_RUN: begin
                life_running = v;
            end
            default: begin
            end
        endcase
        res.cell_state = on_grid ? life_grid[r][c] : 1'b0;
        res.running = life_running;
        return res;
    endfunction

    task automatic send_command(logic [tlg_pkg::CMD_W-1:0] cmd, logic [5:0] r, logic [5:0] c,
                                logic v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady_sender ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, c, r, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_command(cmd, r, c, v));
        items_sent++;
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_grid_size(logic [tlg_pkg::CFG_W-1:0] rows,
                                 logic [tlg_pkg::CFG_W-1:0] cols);
        wait_until_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tlg_pkg::CFG_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        rows_reg = rows;
        i_cfg_idx  <= tlg_pkg::CFG_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        cols_reg = cols;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sizes_tried++;
    endtask

    function automatic logic [5:0] pick_coord(int used);
        if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, used - 1));
    endfunction

    // One session: edit a stopped grid, run a few generations with reads and
    // refused edits in between, then stop and read back. Some beats are noise.
    task automatic run_life_session(int quota);
        int start;
        int nr;
        int nc;
        logic [tlg_pkg::CMD_W-1:0] edit_cmds [3] = '{tlg_pkg::CMD_WRITE, tlg_pkg::CMD_TOGGLE,
                                                      tlg_pkg::CMD_CLEAR};
        start = items_sent;
        nr = size_used(rows_reg);
        nc = size_used(cols_reg);
        steady_sender = ($urandom_range(0, 3) == 0);
        while (items_sent - start < quota) begin
            if ($urandom_range(0, 9) == 0) begin
                send_command(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom),
                             1'($urandom));
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    send_command(tlg_pkg::CMD_CLEAR, pick_coord(nr), pick_coord(nc),
                                 1'($urandom));
                end
                repeat ($urandom_range(2, 12)) begin
                    case ($urandom_range(0, 5))
                        0, 1, 2: send_command(tlg_pkg::CMD_WRITE, pick_coord(nr),
                                              pick_coord(nc), ($urandom_range(0, 2) != 0));
                        3: send_command(tlg_pkg::CMD_TOGGLE, pick_coord(nr), pick_coord(nc),
                                        1'($urandom));
                        default: send_command(tlg_pkg::CMD_READ, pick_coord(nr),
                                              pick_coord(nc), 1'($urandom));
                    endcase
                end
                send_command(tlg_pkg::CMD_SET_RUN, pick_coord(nr), pick_coord(nc), 1'b1);
                repeat ($urandom_range(1, 5)) begin
                    send_command(tlg_pkg::CMD_ADVANCE, pick_coord(nr), pick_coord(nc),
                                 1'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        send_command(tlg_pkg::CMD_READ, pick_coord(nr), pick_coord(nc),
                                     1'($urandom));
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        send_command(edit_cmds[$urandom_range(0, 2)], pick_coord(nr),
                                     pick_coord(nc), 1'($urandom));
                    end
                end
                send_command(tlg_pkg::CMD_SET_RUN, pick_coord(nr), pick_coord(nc), 1'b0);
                repeat ($urandom_range(1, 3)) begin
                    send_command(tlg_pkg::CMD_READ, pick_coord(nr), pick_coord(nc),
                                 1'($urandom));
                end
            end
        end
    endtask

    task automatic test_directed_edits();
        steady_sender = 1'b0;
        send_command(tlg_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
        send_command(tlg_pkg::CMD_READ, 6'd63, 6'd63, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd63, 6'd63, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
        send_command(tlg_pkg::CMD_TOGGLE, 6'd0, 6'd63, 1'b0);
        send_command(tlg_pkg::CMD_TOGGLE, 6'd63, 6'd63, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b0);
        send_command(tlg_pkg::CMD_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_command(CMD_SPARE_6, 6'd5, 6'd5, 1'b1);
        send_command(CMD_SPARE_7, 6'd63, 6'd0, 1'b1);
        // A blinker lying across the column seam, so it flips across the row seam.
        send_command(tlg_pkg::CMD_WRITE, 6'd0, 6'd62, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd0, 6'd63, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd0, 6'd0, 1'b1);
        send_command(tlg_pkg::CMD_SET_RUN, 6'd0, 6'd0, 1'b1);
        send_command(tlg_pkg::CMD_WRITE, 6'd10, 6'd10, 1'b1);
        send_command(tlg_pkg::CMD_TOGGLE, 6'd0, 6'd0, 1'b0);
        send_command(tlg_pkg::CMD_CLEAR, 6'd0, 6'd62, 1'b0);
        send_command(tlg_pkg::CMD_ADVANCE, 6'd63, 6'd63, 1'b0);
        send_command(tlg_pkg::CMD_READ, 6'd1, 6'd63, 1'b0);
        send_command(tlg_pkg::CMD_ADVANCE, 6'd0, 6'd62, 1'b1);
        send_command(tlg_pkg::CMD_READ, 6'd0, 6'd62, 1'b0);
        send_command(tlg_pkg::CMD_SET_RUN, 6'd0, 6'd0, 1'b0);
        send_command(tlg_pkg::CMD_CLEAR, 6'd63, 6'd0, 1'b1);
        send_command(tlg_pkg::CMD_READ, 6'd0, 6'd63, 1'b0);
    endtask

    task automatic test_tiny_torus();
        set_grid_size(7'd1, 7'd1);
        run_life_session(20);
        set_grid_size(7'd2, 7'd2);
        run_life_session(20);
        set_grid_size(7'd1, 7'd2);
        run_life_session(20);
        set_grid_size(7'd2, 7'd1);
        run_life_session(20);
        set_grid_size(7'd3, 7'd3);
        run_life_session(20);
    endtask

    task automatic test_size_extremes();
        set_grid_size(7'd0, 7'd0);
        run_life_session(22);
        set_grid_size(7'd127, 7'd65);
        run_life_session(22);
        set_grid_size(7'd1, 7'd64);
        run_life_session(22);
        set_grid_size(7'd64, 7'd1);
        run_life_session(22);
        set_grid_size(7'd65, 7'd3);
        run_life_session(22);
        set_grid_size(7'd64, 7'd64);
        run_life_session(22);
    endtask

    task automatic test_random_sizes();
        repeat (3) begin
            set_grid_size(7'($urandom_range(3, 12)), 7'($urandom_range(3, 64)));
            run_life_session(26);
        end
        set_grid_size(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
        run_life_session(26);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        case ((cycle_count / 256) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 99) < 65);
            2: m_axis_tready <= (cycle_count % 5 != 0);
            default: m_axis_tready <= (cycle_count % 11 == 0);
        endcase
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        life_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result beat %h at cycle %0d.", m_axis_tdata,
                             cycle_count);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.cell_state || m_axis_tdata[1] !== want.running
                        || m_axis_tdata[2] !== want.refused) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d: cell_state %b/%b running %b/%b refused %b/%b %s",
                                 results_seen, want.cell_state, m_axis_tdata[0],
                                 want.running, m_axis_tdata[1], want.refused,
                                 m_axis_tdata[2], "(expected/actual)");
                    end
                end
            end
        end
    end

    initial begin
        foreach (life_grid[i]) life_grid[i] = '0;
        life_running = 1'b0;
        rows_reg = tlg_pkg::CFG_SIZE_RESET;
        cols_reg = tlg_pkg::CFG_SIZE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edits();
        test_tiny_torus();
        test_size_extremes();
        test_random_sizes();
        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d command beats over %0d grid sizes; %0d generations advanced.",
                 items_sent, sizes_tried, generations_run);
        $display("Compared %0d result beats, %0d mismatching.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/tlg_pkg.sv
rtl/tlg_ctrl.sv
rtl/tlg_datapath.sv
rtl/toroidal_life_grid_engine.sv
tb/sv/toroidal_life_grid_engine_tb.sv
